// ----- src/sem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg: shared types and constants for the rgb sobel edge magnitude block
// frame limits, kernel taps, state encodings and the result tag
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIM_W   = 11;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int COORD_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int GRAD_W  = 12;
  localparam int SUM_W   = 21;
  localparam int NUM_CH  = 3;
  localparam int TAPS    = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam int KERN_X [TAPS] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
  localparam int KERN_Y [TAPS] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

  localparam logic [CH_W-1:0] MAG_MAX = 8'd255;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_SEL, ST_RUN} top_st_t;
  typedef enum logic [1:0] {LN_IDLE, LN_SQ, LN_ITER, LN_DONE} lane_st_t;

  typedef struct packed {
    logic               done;
    logic [CH_W-1:0]    mag;
  } lane_res_t;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               frame_done;
    logic               run_last;
  } res_tag_t;

  // zero counts as one, large values clip to the maximum
  function automatic int eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    int res;
    if (v == '0) res = 1;
    else if (int'(v) > maxv) res = maxv;
    else res = int'(v);
    return res;
  endfunction

endpackage

// ----- src/sem_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_if: channel interfaces for pixels, results and register writes
// valid/ready handshake, payload carried alongside
// ----------------------------------------------------------------------------
interface sem_pix_if import sem_pkg::*; ;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red_in;
  logic [CH_W-1:0] green_in;
  logic [CH_W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    red_edge;
  logic [CH_W-1:0]    green_edge;
  logic [CH_W-1:0]    blue_edge;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_col;
  logic               frame_done;
  logic               run_last;
  modport source (output valid, red_edge, green_edge, blue_edge, pixel_row, pixel_col,
                  frame_done, run_last, input ready);
  modport sink   (input valid, red_edge, green_edge, blue_edge, pixel_row, pixel_col,
                  frame_done, run_last, output ready);
endinterface

interface sem_cfg_if import sem_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/sem_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram: generic single write, single read ram
// registered read data, no reset on contents
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/sem_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_lane: one colour channel of the sobel magnitude
// gradients, sum of squares, then a bit-per-cycle rounded square root
// ----------------------------------------------------------------------------
module sem_lane import sem_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [CH_W-1:0] px [TAPS],
  output lane_res_t       res
);

  lane_st_t                 state_r, state_nxt;
  logic signed [GRAD_W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic [SUM_W-1:0]         s_r;
  logic [CH_W-1:0]          k_r;
  logic [2:0]               bit_r;
  logic [CH_W-1:0]          trial;
  logic [2*CH_W-1:0]        prod;
  logic [23:0]              sq_sum;
  logic [CH_W-1:0]          mag;

  always_comb begin
    gx_nxt = '0;
    gy_nxt = '0;
    for (int i = 0; i < TAPS; i++) begin
      gx_nxt = gx_nxt + GRAD_W'(KERN_X[i]) * $signed({4'b0, px[i]});
      gy_nxt = gy_nxt + GRAD_W'(KERN_Y[i]) * $signed({4'b0, px[i]});
    end
  end

  // squares taken at full width, sign extended first
  assign sq_sum = 24'(gx_r) * 24'(gx_r) + 24'(gy_r) * 24'(gy_r);

  // largest k with k*(k+1) below s, built msb first
  assign trial = k_r | (CH_W'(1) << bit_r);
  assign prod  = 16'(trial) * 16'({1'b0, trial} + 9'd1);

  always_comb begin
    if (s_r == '0) mag = '0;
    else if (k_r == MAG_MAX) mag = MAG_MAX;
    else mag = k_r + CH_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LN_IDLE: if (start) state_nxt = LN_SQ;
      LN_SQ:   state_nxt = LN_ITER;
      LN_ITER: if (bit_r == 3'd0) state_nxt = LN_DONE;
      LN_DONE: if (start) state_nxt = LN_SQ;
      default: state_nxt = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LN_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
    end
    if (state_r == LN_SQ) begin
      s_r   <= sq_sum[SUM_W-1:0];
      k_r   <= '0;
      bit_r <= 3'd7;
    end
    if (state_r == LN_ITER) begin
      if ({{(SUM_W-2*CH_W){1'b0}}, prod} < s_r) begin
        k_r <= trial;
      end
      bit_r <= bit_r - 3'd1;
    end
  end

  assign res.done = (state_r == LN_DONE);
  assign res.mag  = mag;

endmodule

// ----- src/sem_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_merge: output stage
// joins the three lane magnitudes and the tag into one result register
// ----------------------------------------------------------------------------
module sem_merge import sem_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic [CH_W-1:0] mags [NUM_CH],
  input  res_tag_t        tag,
  output logic            free,
  sem_res_if.source       out_chan
);

  logic            valid_r;
  logic [CH_W-1:0] red_r, green_r, blue_r;
  res_tag_t        tag_r;

  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= mags[0];
      green_r <= mags[1];
      blue_r  <= mags[2];
      tag_r   <= tag;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.red_edge   = red_r;
  assign out_chan.green_edge = green_r;
  assign out_chan.blue_edge  = blue_r;
  assign out_chan.pixel_row  = tag_r.row;
  assign out_chan.pixel_col  = tag_r.col;
  assign out_chan.frame_done = tag_r.frame_done;
  assign out_chan.run_last   = tag_r.run_last;

endmodule

// ----- src/sobel_edge_magnitude_rgb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 sobel edge magnitude on rgb pixels
// two line stores, a 3x3 window and three channel lanes feeding one output
// ----------------------------------------------------------------------------
// result path: a pixel's transaction passes the line store read, the select
//   state and the lane square root before its result enters the output register
// acceptance: a new pixel is taken only after every result it releases (0 to 4)
//   is loaded into the output register; the 8-step lane square root sets the pace
// reset: synchronous active low; frame size returns to 1024 x 1024, position
//   and window clear; line stores are not cleared, entries are read only
//   after they were written in the current frame
module sobel_edge_magnitude_rgb import sem_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  sem_pix_if.sink   in_chan,
  sem_res_if.source out_chan,
  sem_cfg_if.sink   cfg_chan
);

  top_st_t          state_r, state_nxt;
  logic [DIM_W-1:0] frame_width_r, frame_height_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [PIX_W-1:0] win_r [3][2];

  // latched transaction
  logic [ROW_W-1:0] pix_row_r;
  logic [COL_W-1:0] pix_col_r;
  logic [PIX_W-1:0] pix_r;
  logic             last_col_r, last_row_r;

  logic [PIX_W-1:0] g_r [3][3];
  logic [3:0]       mask_r, cur_r;
  res_tag_t         tag_r, tag_nxt;

  int               w_i, h_i;
  logic [COL_W-1:0] c_eff;
  logic [ROW_W-1:0] r_eff;
  logic             last_col, last_row;
  logic             in_acc, cfg_acc;

  logic [PIX_W-1:0] above_rd, two_rd;
  logic [PIX_W-1:0] col_new [3];
  logic [3:0]       mask_nxt, cur_nxt;
  logic [1:0]       sel;
  logic [2:0]       rc, cc;

  logic [CH_W-1:0]  lane_px [NUM_CH][TAPS];
  lane_res_t        lane_res [NUM_CH];
  logic [CH_W-1:0]  mags [NUM_CH];
  logic             lanes_done, merge_free, merge_load, lane_start, ram_we;

  // frame geometry
  assign w_i = eff_dim(frame_width_r, MAX_WIDTH);
  assign h_i = eff_dim(frame_height_r, MAX_HEIGHT);
  assign c_eff = (int'(col_r) >= w_i) ? COL_W'(w_i - 1) : col_r;
  assign r_eff = (int'(row_r) >= h_i) ? ROW_W'(h_i - 1) : row_r;
  assign last_col = (int'(c_eff) == w_i - 1);
  assign last_row = (int'(r_eff) == h_i - 1);

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // line stores: read at the accepted column, written back in the next cycle
  assign ram_we = (state_r == ST_RD);

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_col_r),
    .wdata (pix_r),
    .raddr (c_eff),
    .rdata (above_rd)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_two_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pix_col_r),
    .wdata (col_new[1]),
    .raddr (c_eff),
    .rdata (two_rd)
  );

  // new column of the window, rows above the frame read as zero
  assign col_new[0] = (pix_row_r >= ROW_W'(2)) ? two_rd : '0;
  assign col_new[1] = (pix_row_r >= ROW_W'(1)) ? above_rd : '0;
  assign col_new[2] = pix_r;

  // which results this pixel releases, in raster order
  always_comb begin
    mask_nxt[0] = (pix_row_r != '0) && (pix_col_r != '0);
    mask_nxt[1] = (pix_row_r != '0) && last_col_r;
    mask_nxt[2] = last_row_r && (pix_col_r != '0);
    mask_nxt[3] = last_row_r && last_col_r;
  end

  // pick the earliest pending result
  always_comb begin
    priority if (mask_r[0]) sel = 2'd0;
    else if (mask_r[1])     sel = 2'd1;
    else if (mask_r[2])     sel = 2'd2;
    else                    sel = 2'd3;
  end

  assign cur_nxt = 4'(1) << sel;
  assign rc = sel[1] ? 3'd2 : 3'd1;
  assign cc = sel[0] ? 3'd2 : 3'd1;

  // 3x3 neighbourhood per channel, zero beyond the newest row and column
  always_comb begin
    logic [2:0]       ra, cb;
    logic [PIX_W-1:0] p;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          ra = rc + 3'(a) - 3'd1;
          cb = cc + 3'(b) - 3'd1;
          p  = (ra > 3'd2 || cb > 3'd2) ? '0 : g_r[ra[1:0]][cb[1:0]];
          lane_px[ch][a*3+b] = p[PIX_W-1-CH_W*ch -: CH_W];
        end
      end
    end
  end

  always_comb begin
    logic [31:0] row_w, col_w;
    row_w = sel[1] ? 32'(pix_row_r) : 32'(pix_row_r) - 32'd1;
    col_w = sel[0] ? 32'(pix_col_r) : 32'(pix_col_r) - 32'd1;
    tag_nxt.row        = row_w[COORD_W-1:0];
    tag_nxt.col        = col_w[COORD_W-1:0];
    tag_nxt.frame_done = (sel == 2'd3);
    tag_nxt.run_last   = ((mask_r & ~cur_nxt) == 4'd0);
  end

  // one lane per colour channel
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    sem_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (lane_start),
      .px    (lane_px[ch]),
      .res   (lane_res[ch])
    );
    assign mags[ch] = lane_res[ch].mag;
  end

  assign lanes_done = lane_res[0].done && lane_res[1].done && lane_res[2].done;

  sem_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (merge_load),
    .mags     (mags),
    .tag      (tag_r),
    .free     (merge_free),
    .out_chan (out_chan)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = 1'b0;
    lane_start    = 1'b0;
    merge_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = (mask_nxt != 4'd0) ? ST_SEL : ST_IDLE;
      end
      ST_SEL: begin
        lane_start = 1'b1;
        state_nxt  = ST_RUN;
      end
      ST_RUN: begin
        if (lanes_done && merge_free) begin
          merge_load = 1'b1;
          state_nxt  = ((mask_r & ~cur_r) != 4'd0) ? ST_SEL : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= DIM_W'(1024);
      frame_height_r <= DIM_W'(1024);
      row_r          <= '0;
      col_r          <= '0;
      mask_r         <= '0;
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= '0;
        win_r[i][1] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_acc && (cfg_chan.index == REG_FRAME_WIDTH ||
                      cfg_chan.index == REG_FRAME_HEIGHT)) begin
        if (cfg_chan.index == REG_FRAME_WIDTH) frame_width_r <= cfg_chan.data;
        else frame_height_r <= cfg_chan.data;
        // frame restarts
        row_r <= '0;
        col_r <= '0;
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= '0;
          win_r[i][1] <= '0;
        end
      end else if (state_r == ST_RD) begin
        mask_r <= mask_nxt;
        if (last_col_r) begin
          col_r <= '0;
          row_r <= last_row_r ? '0 : pix_row_r + ROW_W'(1);
          for (int i = 0; i < 3; i++) begin
            win_r[i][0] <= '0;
            win_r[i][1] <= '0;
          end
        end else begin
          col_r <= pix_col_r + COL_W'(1);
          row_r <= pix_row_r;
          for (int i = 0; i < 3; i++) begin
            win_r[i][0] <= win_r[i][1];
            win_r[i][1] <= col_new[i];
          end
        end
      end else if (merge_load) begin
        mask_r <= mask_r & ~cur_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_row_r  <= r_eff;
      pix_col_r  <= c_eff;
      pix_r      <= {in_chan.red_in, in_chan.green_in, in_chan.blue_in};
      last_col_r <= last_col;
      last_row_r <= last_row;
    end
    if (state_r == ST_RD) begin
      for (int i = 0; i < 3; i++) begin
        g_r[i][0] <= win_r[i][0];
        g_r[i][1] <= win_r[i][1];
        g_r[i][2] <= col_new[i];
      end
    end
    if (state_r == ST_SEL) begin
      cur_r <= cur_nxt;
      tag_r <= tag_nxt;
    end
  end

  // checks
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_res[0].done == lane_res[1].done) && (lane_res[1].done == lane_res[2].done))
    else $error("colour lanes out of step");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_RD))
    else $error("transaction accepted without line store read");

  a_sel_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL) |-> (mask_r != 4'd0))
    else $error("result selected with nothing pending");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    merge_load |-> merge_free)
    else $error("output register overwritten");

  a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ($onehot(cur_r) && ((cur_r & mask_r) != 4'd0)))
    else $error("current result not pending");

endmodule
